FILE: rtl/balanced_modular_inverse_core_macros.svh
// Assertion macros used by the balanced modular inverse checker.
`ifndef BALANCED_MODULAR_INVERSE_CORE_MACROS_SVH
`define BALANCED_MODULAR_INVERSE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define BMI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define BMI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bmi_pkg.sv
// Package: field widths, sequencer states and divider status type.
package bmi_pkg;

   localparam int FUNC_W = 1;
   localparam int NUM_W  = 32;
   localparam int MOD_W  = 31;
   localparam int RES_W  = 31;
   localparam int Y_W    = 32;
   localparam int CAND_W = 33;

   localparam logic FUNC_REM = 1'b0;
   localparam logic FUNC_INV = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_NDIV = 7'b0000010,
      ST_ECHK = 7'b0000100,
      ST_EDIV = 7'b0001000,
      ST_EMUL = 7'b0010000,
      ST_EUPD = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] remainder;
   } div_stat_type;

endpackage

FILE: rtl/bmi_req_if.sv
// Request channel interface: operation, number and modulus.
interface bmi_req_if;
   logic                          valid;
   logic                          ready;
   logic [bmi_pkg::FUNC_W-1:0]    func;
   logic signed [bmi_pkg::NUM_W-1:0] number;
   logic [bmi_pkg::MOD_W-1:0]     modulus;

   modport source (output valid, func, number, modulus, input ready);
   modport sink (input valid, func, number, modulus, output ready);
endinterface

FILE: rtl/bmi_rsp_if.sv
// Response channel interface: balanced result and error flag.
interface bmi_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [bmi_pkg::RES_W-1:0] result;
   logic                             error;

   modport source (output valid, result, error, input ready);
   modport sink (input valid, result, error, output ready);
endinterface

FILE: rtl/bmi_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module bmi_divider #(
   parameter int DVD_W = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DVD_W-1:0]          dividend,
   input  logic [bmi_pkg::MOD_W-1:0] divisor,
   output bmi_pkg::div_stat_type     stat,
   output logic [DVD_W-1:0]          quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [bmi_pkg::MOD_W-1:0] rem_ff, rem_in;
   logic [bmi_pkg::MOD_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0]          quo_ff, quo_in;
   logic [bmi_pkg::MOD_W:0]   trial;
   logic [bmi_pkg::MOD_W+1:0] diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diff    = {1'b0, trial} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!diff[bmi_pkg::MOD_W+1]) begin
            rem_in = diff[bmi_pkg::MOD_W-1:0];
         end else begin
            rem_in = trial[bmi_pkg::MOD_W-1:0];
         end
         quo_in = {quo_ff[DVD_W-2:0], ~diff[bmi_pkg::MOD_W+1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign stat.done      = done_ff;
   assign stat.remainder = rem_ff;
   assign quotient       = quo_ff;

endmodule

FILE: rtl/balanced_modular_inverse_core.sv
// Top level: balanced remainder and balanced modular inverse sequencer.
// One item at a time: func 0 gives the truncated remainder of number by modulus, func 1 the
// inverse of number modulo modulus by the extended Euclidean algorithm; either answer is
// returned in balanced form, -floor(m/2) .. floor(m/2). A zero modulus, or a number with no
// inverse, returns error = 1 and result = 0. All division goes through one shared restoring
// divider of D = max(WORD_BITS, 31) bits that yields one quotient bit per cycle. The remainder
// takes one division; the inverse then runs a check, a division, a multiply and an update for
// each Euclid round (up to about 46 rounds); a zero modulus skips the divider. The request side
// is ready only while idle; the result register lets the next item start while an earlier
// result waits for its transfer.
module balanced_modular_inverse_core #(
   parameter int WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   bmi_req_if.sink          req_ch,
   bmi_rsp_if.source        rsp_ch
);

   localparam int DVD_W = (WORD_BITS > bmi_pkg::MOD_W) ? WORD_BITS : bmi_pkg::MOD_W;

   bmi_pkg::state_type               state_ff, state_in;
   logic                             func_ff, func_in;
   logic                             neg_ff, neg_in;
   logic [bmi_pkg::MOD_W-1:0]        mod_ff, mod_in;
   logic [bmi_pkg::MOD_W-1:0]        a1_ff, a1_in;
   logic [bmi_pkg::MOD_W-1:0]        a2_ff, a2_in;
   logic [bmi_pkg::MOD_W-1:0]        q_ff, q_in;
   logic signed [bmi_pkg::Y_W-1:0]   y1_ff, y1_in;
   logic signed [bmi_pkg::Y_W-1:0]   y2_ff, y2_in;
   logic [bmi_pkg::Y_W-1:0]          prod_ff, prod_in;
   logic signed [bmi_pkg::CAND_W-1:0] cand_ff, cand_in;
   logic                             err_ff, err_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [bmi_pkg::RES_W-1:0] rsp_result_ff, rsp_result_in;
   logic                             rsp_error_ff, rsp_error_in;

   logic                             in_xfer;
   logic                             rsp_load;
   logic signed [63:0]               num64;
   logic [WORD_BITS-1:0]             num_ext;
   logic [WORD_BITS-1:0]             mag;
   logic                             div_start;
   logic [DVD_W-1:0]                 div_dividend;
   logic [bmi_pkg::MOD_W-1:0]        div_divisor;
   bmi_pkg::div_stat_type            div_stat;
   logic [DVD_W-1:0]                 div_quotient;
   logic [bmi_pkg::MOD_W-1:0]        rem;
   logic signed [bmi_pkg::CAND_W-1:0] m_s;
   logic signed [bmi_pkg::CAND_W-1:0] half_s;
   logic signed [bmi_pkg::CAND_W-1:0] bal;
   logic [bmi_pkg::Y_W-1:0]          q_ext;
   logic [bmi_pkg::Y_W-1:0]          y2_bits;

   bmi_divider #(
      .DVD_W (DVD_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   assign req_ch.ready = (state_ff == bmi_pkg::ST_IDLE);
   assign in_xfer      = req_ch.valid & req_ch.ready;

   always_comb begin
      num64   = 64'(unsigned'(req_ch.number));
      num_ext = num64[WORD_BITS-1:0];
      mag     = num_ext[WORD_BITS-1] ? (~num_ext + WORD_BITS'(1)) : num_ext;
      rem     = div_stat.remainder;
      m_s     = signed'({2'b00, mod_ff});
      half_s  = signed'({3'b000, mod_ff[bmi_pkg::MOD_W-1:1]});
      q_ext   = {1'b0, q_ff};
      y2_bits = unsigned'(y2_ff);
      bal     = cand_ff;
      if (cand_ff < -half_s) begin
         bal = cand_ff + m_s;
      end else if (cand_ff > half_s) begin
         bal = cand_ff - m_s;
      end
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      neg_in       = neg_ff;
      mod_in       = mod_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      q_in         = q_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      prod_in      = prod_ff;
      cand_in      = cand_ff;
      err_in       = err_ff;
      div_start    = 1'b0;
      div_dividend = DVD_W'(a1_ff);
      div_divisor  = a2_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         bmi_pkg::ST_IDLE: begin
            div_dividend = DVD_W'(mag);
            div_divisor  = req_ch.modulus;
            if (in_xfer) begin
               func_in = req_ch.func;
               neg_in  = num_ext[WORD_BITS-1];
               mod_in  = req_ch.modulus;
               err_in  = 1'b0;
               cand_in = '0;
               if (req_ch.modulus == '0) begin
                  err_in   = 1'b1;
                  state_in = bmi_pkg::ST_FIN;
               end else begin
                  div_start = 1'b1;
                  state_in  = bmi_pkg::ST_NDIV;
               end
            end
         end
         bmi_pkg::ST_NDIV: begin
            if (div_stat.done) begin
               if (func_ff == bmi_pkg::FUNC_REM) begin
                  cand_in  = neg_ff ? -signed'({2'b00, rem}) : signed'({2'b00, rem});
                  state_in = bmi_pkg::ST_FIN;
               end else begin
                  a1_in    = mod_ff;
                  a2_in    = (neg_ff && rem != '0) ? (mod_ff - rem) : rem;
                  y1_in    = '0;
                  y2_in    = bmi_pkg::Y_W'(1);
                  state_in = bmi_pkg::ST_ECHK;
               end
            end
         end
         bmi_pkg::ST_ECHK: begin
            if (a2_ff == '0) begin
               err_in   = 1'b1;
               cand_in  = '0;
               state_in = bmi_pkg::ST_FIN;
            end else if (a2_ff == bmi_pkg::MOD_W'(1)) begin
               cand_in  = y2_ff[bmi_pkg::Y_W-1] ? (bmi_pkg::CAND_W'(y2_ff) + m_s)
                                                : bmi_pkg::CAND_W'(y2_ff);
               state_in = bmi_pkg::ST_FIN;
            end else begin
               div_start = 1'b1;
               state_in  = bmi_pkg::ST_EDIV;
            end
         end
         bmi_pkg::ST_EDIV: begin
            if (div_stat.done) begin
               q_in     = div_quotient[bmi_pkg::MOD_W-1:0];
               a1_in    = a2_ff;
               a2_in    = rem;
               state_in = bmi_pkg::ST_EMUL;
            end
         end
         bmi_pkg::ST_EMUL: begin
            prod_in  = bmi_pkg::Y_W'(q_ext * y2_bits);
            state_in = bmi_pkg::ST_EUPD;
         end
         bmi_pkg::ST_EUPD: begin
            y1_in    = y2_ff;
            y2_in    = y1_ff - signed'(prod_ff);
            state_in = bmi_pkg::ST_ECHK;
         end
         bmi_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = bmi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bmi_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_error_in  = rsp_error_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = err_ff ? '0 : bal[bmi_pkg::RES_W-1:0];
         rsp_error_in  = err_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmi_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      neg_ff        <= neg_in;
      mod_ff        <= mod_in;
      a1_ff         <= a1_in;
      a2_ff         <= a2_in;
      q_ff          <= q_in;
      y1_ff         <= y1_in;
      y2_ff         <= y2_in;
      prod_ff       <= prod_in;
      cand_ff       <= cand_in;
      err_ff        <= err_in;
      rsp_result_ff <= rsp_result_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.result = rsp_result_ff;
   assign rsp_ch.error  = rsp_error_ff;

endmodule

FILE: rtl/bmi_checker.sv
// Port-level checker for the balanced modular inverse core, with its bind.
`include "balanced_modular_inverse_core_macros.svh"

module bmi_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [bmi_pkg::RES_W-1:0] rsp_result,
   input logic                             rsp_error
);

   `BMI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result) && $stable(rsp_error), "stalled response changed")
   `BMI_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request side still ready after a transfer")
   `BMI_ASSERT_NOW(a_error_zero, rsp_valid && rsp_error, rsp_result == '0, "error response with nonzero result")
   `BMI_ASSERT_NOW(a_balanced_range, rsp_valid, rsp_result != signed'(31'h4000_0000), "result outside balanced range")

endmodule

bind balanced_modular_inverse_core bmi_checker u_bmi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_result (rsp_ch.result),
   .rsp_error  (rsp_ch.error)
);
